// ===== rtl/tcf_pkg.sv =====
package tcf_pkg;

  localparam logic [7:0] CMD_IAC    = 8'hFF;
  localparam logic [7:0] CMD_DONT   = 8'hFE;
  localparam logic [7:0] CMD_DO     = 8'hFD;
  localparam logic [7:0] CMD_WONT   = 8'hFC;
  localparam logic [7:0] CMD_WILL   = 8'hFB;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] MARK_BYTE  = 8'h00;

  localparam logic [1:0] CH_DATA  = 2'd0;
  localparam logic [1:0] CH_REPLY = 2'd1;
  localparam logic [1:0] CH_MARK  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_OPT  = 2'd2
  } tcf_phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_REPLY = 2'd2
  } tcf_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_last;
  } tcf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] channel;
    logic       run_last;
  } tcf_out_t;

  // Task handed from the parser to the emitter
  typedef struct packed {
    tcf_kind_t  kind;
    logic [7:0] byte_val;  // data byte, or option byte for a reply
    logic [7:0] ans;       // DONT or WONT for a reply
    logic       mark;      // end-of-chunk marker follows
  } tcf_task_t;

endpackage

// ===== rtl/tcf_front.sv =====
module tcf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tcf_pkg::tcf_in_t  item,
  output logic              task_valid,
  output tcf_pkg::tcf_task_t task_out
);
  import tcf_pkg::*;

  tcf_phase_t phase, phase_next;
  logic [7:0] held_verb, held_verb_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      held_verb <= 8'h00;
    end else if (accept) begin
      phase     <= phase_next;
      held_verb <= held_verb_next;
    end
  end

  always_comb begin
    phase_next        = PH_IDLE;
    held_verb_next    = held_verb;
    task_out.kind     = KIND_NONE;
    task_out.byte_val = item.in_byte;
    task_out.ans      = CMD_WONT;
    task_out.mark     = item.chunk_last;
    case (phase)
      PH_CMD: begin
        if (item.in_byte == CMD_IAC) begin
          task_out.kind = KIND_DATA;
        end else if (item.in_byte >= CMD_WILL && item.in_byte <= CMD_DONT) begin
          held_verb_next = item.in_byte;
          phase_next     = PH_OPT;
        end
      end
      PH_OPT: begin
        task_out.kind = KIND_REPLY;
        task_out.ans  = (held_verb == CMD_WILL || held_verb == CMD_WONT) ? CMD_DONT
                                                                          : CMD_WONT;
      end
      default: begin
        if (item.in_byte == 8'h00) begin
          task_out.kind     = KIND_DATA;
          task_out.byte_val = SPACE_BYTE;
        end else if (item.in_byte == CMD_IAC) begin
          phase_next = PH_CMD;
        end else begin
          task_out.kind = KIND_DATA;
        end
      end
    endcase
    // bytes that cause nothing are never queued
    task_valid = accept && (task_out.kind != KIND_NONE || task_out.mark);
  end

endmodule

// ===== rtl/tcf_queue.sv =====
module tcf_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  tcf_pkg::tcf_task_t wr_data,
  input  logic               rd_en,
  output tcf_pkg::tcf_task_t rd_data,
  output logic               q_full,
  output logic               q_empty
);
  import tcf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  tcf_task_t      slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/tcf_back.sv =====
module tcf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  tcf_pkg::tcf_task_t head,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output tcf_pkg::tcf_out_t  result
);
  import tcf_pkg::*;

  logic       o_valid;
  logic [1:0] idx;
  logic [2:0] n_res;
  logic       load, is_last;
  tcf_out_t   res_next;

  assign empty = !o_valid;
  assign load  = !q_empty && (!o_valid || pop);

  always_comb begin
    case (head.kind)
      KIND_REPLY: n_res = 3'd3;
      KIND_DATA:  n_res = 3'd1;
      default:    n_res = 3'd0;
    endcase
    n_res   = n_res + {2'b00, head.mark};
    is_last = ({1'b0, idx} + 3'd1) == n_res;
    q_pop   = load && is_last;

    res_next.out_byte = MARK_BYTE;
    res_next.channel  = CH_MARK;
    res_next.run_last = is_last;
    if (head.kind == KIND_REPLY && idx != 2'd3) begin
      res_next.channel = CH_REPLY;
      case (idx)
        2'd0:    res_next.out_byte = CMD_IAC;
        2'd1:    res_next.out_byte = head.ans;
        default: res_next.out_byte = head.byte_val;
      endcase
    end else if (head.kind == KIND_DATA && idx == 2'd0) begin
      res_next.channel  = CH_DATA;
      res_next.out_byte = head.byte_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= 2'd0;
    end else begin
      if (load) begin
        o_valid <= 1'b1;
        idx     <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= res_next;
  end

endmodule

// ===== rtl/telnet_command_filter.sv =====
// Each byte's task is queued, then its results are loaded into the output register.
// Throughput: one byte in per cycle unless full, if each gives at most one result;
//   results drain one per cycle while pop is high; a reply plus marker gives four.
// A task queue of QUEUE_DEPTH entries between parser and emitter absorbs reply bursts.
// Reset (rst, synchronous, active high) returns the parser to idle and empties the queue
//   and output register.
module telnet_command_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tcf_pkg::tcf_in_t  item,
  output logic              empty,
  input  logic              pop,
  output tcf_pkg::tcf_out_t result
);
  import tcf_pkg::*;

  // Front: parser classifies each byte into one task (or none)
  logic      accept;
  logic      task_valid;
  tcf_task_t task_in, task_head;
  logic      q_full, q_empty, q_pop;

  // full only follows the task queue; the parser itself never stalls
  assign full   = q_full;
  assign accept = push && !q_full;

  tcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .task_valid (task_valid),
    .task_out   (task_in)
  );

  // Short queue decoupling parse from emission
  tcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (task_valid),
    .wr_data (task_in),
    .rd_en   (q_pop),
    .rd_data (task_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Back: walks each task through its results into a registered output;
  // the output reloads in the same cycle it is popped if the queue holds a task
  tcf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (task_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== test/tb_telnet_command_filter.sv =====
module tb_telnet_command_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import tcf_pkg::*;

  // Pause after the last expected transaction: the task queue and output register
  // plus a burst of reply bytes still draining, with ample margin.
  localparam int SETTLE_CYCLES = 16;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     push  = 1'b0;
  logic     full;
  tcf_in_t  item  = '0;
  logic     empty;
  logic     pop   = 1'b0;
  tcf_out_t result;

  // Bytes waiting to go out on the link side, and the results the
  // filter owes us, oldest first.
  tcf_in_t  link_bytes[$];
  tcf_out_t owed_results[$];

  // Own copy of the parser state.
  tcf_phase_t parse_st  = PH_IDLE;
  logic [7:0] verb_held = 8'h00;

  int  bad_cnt    = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  bit  tx_calm    = 1'b0;
  bit  rx_calm    = 1'b0;

  telnet_command_filter dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length for the next transaction on one side. Every so often the side
  // flips into a calm stretch where it never idles, so back-to-back traffic
  // gets its share of the run as well.
  function automatic int idle_draw(inout bit calm);
    if ($urandom_range(0, 31) == 0)
      calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Work out what one received byte produces and append it to owed_results.
  // Reply bytes come first, then the end-of-chunk marker; the final one
  // carries run_last.
  task automatic filter_byte(input tcf_in_t rx);
    tcf_out_t   outs[$];
    tcf_out_t   r;
    logic [7:0] b;
    logic [7:0] answer;
    b = rx.in_byte;
    case (parse_st)
      PH_CMD: begin
        if (b == CMD_IAC) begin
          // doubled IAC is a literal 0xFF
          r = '{out_byte: CMD_IAC, channel: CH_DATA, run_last: 1'b0};
          outs.push_back(r);
          parse_st = PH_IDLE;
        end else if (b >= CMD_WILL && b <= CMD_DONT) begin
          verb_held = b;
          parse_st  = PH_OPT;
        end else begin
          // SE..SB and anything unknown: swallowed with the IAC
          parse_st = PH_IDLE;
        end
      end
      PH_OPT: begin
        // refuse everything: WILL/WONT gets DONT, DO/DONT gets WONT
        answer = (verb_held == CMD_WILL || verb_held == CMD_WONT) ? CMD_DONT : CMD_WONT;
        r = '{out_byte: CMD_IAC, channel: CH_REPLY, run_last: 1'b0};
        outs.push_back(r);
        r.out_byte = answer;
        outs.push_back(r);
        r.out_byte = b;       // option byte echoed, zero included
        outs.push_back(r);
        parse_st = PH_IDLE;
      end
      default: begin
        // idle, and the unused phase behaves as idle
        parse_st = PH_IDLE;
        if (b == 8'h00) begin
          r = '{out_byte: SPACE_BYTE, channel: CH_DATA, run_last: 1'b0};
          outs.push_back(r);
        end else if (b == CMD_IAC) begin
          parse_st = PH_CMD;
        end else begin
          r = '{out_byte: b, channel: CH_DATA, run_last: 1'b0};
          outs.push_back(r);
        end
      end
    endcase
    if (rx.chunk_last) begin
      r = '{out_byte: MARK_BYTE, channel: CH_MARK, run_last: 1'b0};
      outs.push_back(r);
    end
    if (outs.size() > 0)
      outs[outs.size() - 1].run_last = 1'b1;
    foreach (outs[i])
      owed_results.push_back(outs[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic lst);
    tcf_in_t t;
    t.in_byte    = b;
    t.chunk_last = lst;
    link_bytes.push_back(t);
  endtask

  function automatic logic rand_last();
    return ($urandom_range(0, 7) == 0);
  endfunction

  // Link side. A byte on offer stays put until taken; the prediction is made
  // on the edge where the transaction completes, using the byte then on offer.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        filter_byte(item);
        gap_left = idle_draw(tx_calm);
      end else if (!push && gap_left > 0) begin
        gap_left--;
      end
      if (push && full) begin
        // held off: keep offering the same byte
      end else if (gap_left == 0 && link_bytes.size() > 0) begin
        item <= link_bytes.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side. Every taken transaction is checked against the oldest owed
  // result; pop is left high while empty so results are taken as soon as
  // they show up, unless a stall has been drawn.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected result: byte %02h chan %0d last %0d",
                     result.out_byte, result.channel, result.run_last);
        end else begin
          if (result.out_byte !== owed_results[0].out_byte ||
              result.channel  !== owed_results[0].channel  ||
              result.run_last !== owed_results[0].run_last) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                       owed_results[0].out_byte, owed_results[0].channel,
                       owed_results[0].run_last, result.out_byte, result.channel,
                       result.run_last);
          end
          void'(owed_results.pop_front());
        end
        stall_left = idle_draw(rx_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      pop <= (stall_left == 0);
    end
  end

  initial begin
    int rand_n;
    int pick;
    logic [7:0] verb;

    // --- directed part ---
    queue_byte(8'h00, 1'b0);          // zero outside a command -> space
    queue_byte(8'h41, 1'b1);          // plain data plus marker
    queue_byte(CMD_IAC, 1'b1);        // byte with no output still marks the chunk
    queue_byte(CMD_IAC, 1'b0);        // ...and the state carries over: doubled IAC
    queue_byte(CMD_IAC, 1'b0);        // WILL: full reply then marker
    queue_byte(CMD_WILL, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(CMD_IAC, 1'b0);        // WONT with zero as the option
    queue_byte(CMD_WONT, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(CMD_IAC, 1'b0);        // DO with 0xFF as the option
    queue_byte(CMD_DO, 1'b0);
    queue_byte(CMD_IAC, 1'b0);
    queue_byte(CMD_IAC, 1'b0);        // DONT
    queue_byte(CMD_DONT, 1'b1);
    queue_byte(8'h18, 1'b0);
    queue_byte(CMD_IAC, 1'b0);        // SE dropped
    queue_byte(8'hF0, 1'b0);
    queue_byte(CMD_IAC, 1'b0);        // SB dropped, payload passes
    queue_byte(8'hFA, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(CMD_IAC, 1'b0);        // unknown command: zero
    queue_byte(8'h00, 1'b0);
    queue_byte(CMD_IAC, 1'b1);        // unknown command: mid-range byte
    queue_byte(8'h80, 1'b0);

    // --- random part: mostly well-formed sequences, some raw noise ---
    rand_n = 0;
    while (rand_n < 450) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_byte(8'($urandom_range(0, 254)), rand_last());
        rand_n += 1;
      end else if (pick < 40) begin
        queue_byte(8'h00, rand_last());
        rand_n += 1;
      end else if (pick < 48) begin
        queue_byte(CMD_IAC, rand_last());
        queue_byte(CMD_IAC, rand_last());
        rand_n += 2;
      end else if (pick < 60) begin
        queue_byte(CMD_IAC, rand_last());
        queue_byte(8'h F0 + 8'($urandom_range(0, 10)), rand_last());
        rand_n += 2;
      end else if (pick < 82) begin
        verb = CMD_WILL + 8'($urandom_range(0, 3));
        queue_byte(CMD_IAC, rand_last());
        queue_byte(verb, rand_last());
        queue_byte(8'($urandom_range(0, 255)), rand_last());
        rand_n += 3;
      end else if (pick < 88) begin
        queue_byte(CMD_IAC, rand_last());
        queue_byte(8'($urandom_range(0, 8'hEF)), rand_last());
        rand_n += 2;
      end else begin
        queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        rand_n += 1;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all bytes handed over
    while (link_bytes.size() != 0 || push)
      @(posedge clk);
    // every owed result taken
    while (owed_results.size() != 0)
      @(posedge clk);
    // anything extra would turn up as an unexpected result in this window
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (owed_results.size() != 0) begin
      bad_cnt++;
      $display("%0d results never arrived", owed_results.size());
    end
    if (bad_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under half a millisecond.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
